// ===== design/bucketed_hash_table_core_macros.svh =====
`ifndef BUCKETED_HASH_TABLE_CORE_MACROS_SVH
`define BUCKETED_HASH_TABLE_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BHT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bht: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bht: next-cycle check failed");

`endif

// ===== design/bht_pkg.sv =====
package bht_pkg;

   localparam int BUCKETS  = 10;
   localparam int DEPTH    = 8;
   localparam int VAL_W    = 31;
   localparam int PROBES_W = 4;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = (BUCKETS * DEPTH > 1) ? $clog2(BUCKETS * DEPTH) : 1;

   // The bucket index comes from a multiply by the scaled reciprocal of the
   // bucket count, exact for every value of VAL_W bits, then one subtract.
   localparam int              RECIP_SHIFT = VAL_W + $clog2(BUCKETS);
   localparam longint unsigned RECIP       =
      ((64'd1 << RECIP_SHIFT) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
   localparam int              PROD_W      = 2 * VAL_W + 1;
   localparam int              STEPS       = 2;
   localparam int              STEP_W      = 1;

   // Work queue between the front and back ends; the depth is a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PROBES_W-1:0] probes;
   } rsp_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [VAL_W-1:0] value;
      logic [BKT_W-1:0] bucket;
   } work_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_stat_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_HAND
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_FILL,
      BACK_SCAN
   } back_state_type;

endpackage

// ===== design/bht_queue.sv =====
module bht_queue import bht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  work_type push_data,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);

   work_type          slots_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/bht_front.sv =====
module bht_front import bht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     hand_push,
   input  logic     hand_full,
   output work_type hand_data
);

   front_state_type   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VAL_W-1:0]  quot_ff, quot_in;
   logic [BKT_W-1:0]  rem_ff, rem_in;
   req_type           item_ff, item_in;
   logic              accept, advance;
   logic [PROD_W-1:0] product;
   logic [VAL_W-1:0]  quot_back;
   logic [VAL_W-1:0]  diff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_push) state_in = FRONT_DIVIDE;
         end
         FRONT_DIVIDE: begin
            if (step_ff == STEP_W'(STEPS - 1)) state_in = FRONT_HAND;
         end
         FRONT_HAND: begin
            if (!hand_full) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_full  = (state_ff != FRONT_IDLE);
      hand_push = (state_ff == FRONT_HAND);
      accept    = (state_ff == FRONT_IDLE) && req_push;
      advance   = (state_ff == FRONT_DIVIDE);
   end

   // The quotient comes from the scaled reciprocal in the first step, and the
   // remainder from one constant multiply and subtract in the second.
   always_comb begin
      product   = PROD_W'(item_ff.value) * PROD_W'(RECIP);
      quot_back = quot_ff * VAL_W'(BUCKETS);
      diff      = item_ff.value - quot_back;
   end

   always_comb begin
      item_in = item_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (accept) begin
         item_in = req_data;
         step_in = '0;
      end else if (advance) begin
         step_in = step_ff + STEP_W'(1);
         if (step_ff == '0) begin
            quot_in = VAL_W'(product >> RECIP_SHIFT);
         end else begin
            rem_in = diff[BKT_W-1:0];
         end
      end
   end

   assign hand_data = '{cmd: item_ff.cmd, value: item_ff.value, bucket: rem_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

// ===== design/bht_back.sv =====
module bht_back import bht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          work_empty,
   output logic          work_pop,
   input  work_type      work_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_data,
   output back_stat_type stat
);

   logic [VAL_W-1:0]  entry_mem [BUCKETS * DEPTH];
   logic [FILL_W-1:0] fill_mem  [BUCKETS];

   back_state_type    state_ff, state_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   work_type          item_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] slot_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic [BKT_W-1:0]  fill_rd_addr, fill_wr_addr;
   logic [FILL_W-1:0] fill_rd_data, fill_wr_data;
   logic              fill_we;
   logic [ADDR_W-1:0] entry_rd_addr, entry_wr_addr;
   logic [VAL_W-1:0]  entry_rd_data;
   logic              entry_we;

   logic              start, done;
   rsp_type           result;
   logic [FILL_W-1:0] slot_next;
   logic              hit, last, fill_full, fill_zero;

   assign slot_next = slot_ff + FILL_W'(1);
   assign hit       = (entry_rd_data == item_ff.value);
   assign last      = (slot_next == fill_ff);
   assign fill_full = (fill_rd_data == FILL_W'(DEPTH));
   assign fill_zero = (fill_rd_data == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            if (clr_ff == BKT_W'(BUCKETS - 1)) state_in = BACK_IDLE;
         end
         BACK_IDLE: begin
            if (start) state_in = BACK_FILL;
         end
         BACK_FILL: begin
            if (item_ff.cmd == CMD_SEARCH && !fill_zero) state_in = BACK_SCAN;
            else state_in = BACK_IDLE;
         end
         BACK_SCAN: begin
            if (hit || last) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      start         = (state_ff == BACK_IDLE) && !work_empty && (!rsp_valid_ff || rsp_pop);
      work_pop      = start;
      fill_rd_addr  = work_data.bucket;
      fill_we       = 1'b0;
      fill_wr_addr  = item_ff.bucket;
      fill_wr_data  = fill_rd_data + FILL_W'(1);
      entry_we      = 1'b0;
      entry_wr_addr = base_ff + ADDR_W'(fill_rd_data);
      entry_rd_addr = base_ff;
      done          = 1'b0;
      result        = '{status: STATUS_INSERTED, probes: '0};
      clr_in        = clr_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            fill_we      = 1'b1;
            fill_wr_addr = clr_ff;
            fill_wr_data = '0;
            clr_in       = clr_ff + BKT_W'(1);
         end
         BACK_FILL: begin
            if (item_ff.cmd == CMD_INSERT) begin
               done = 1'b1;
               if (fill_full) begin
                  result.status = STATUS_FULL;
               end else begin
                  entry_we = 1'b1;
                  fill_we  = 1'b1;
               end
            end else if (fill_zero) begin
               done          = 1'b1;
               result.status = STATUS_NOT_FOUND;
            end
         end
         BACK_SCAN: begin
            entry_rd_addr = base_ff + ADDR_W'(slot_next);
            result.probes = PROBES_W'(slot_next);
            if (hit) begin
               done          = 1'b1;
               result.status = STATUS_FOUND;
            end else if (last) begin
               done          = 1'b1;
               result.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) rsp_valid_in = 1'b1;
      else if (rsp_pop) rsp_valid_in = 1'b0;
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign stat.clearing  = (state_ff == BACK_CLEAR);
   assign stat.busy      = (state_ff == BACK_FILL) || (state_ff == BACK_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= work_data;
         base_ff <= ADDR_W'(work_data.bucket) * ADDR_W'(DEPTH);
      end
      if (state_ff == BACK_FILL) begin
         fill_ff <= fill_rd_data;
         slot_ff <= '0;
      end else if (state_ff == BACK_SCAN) begin
         slot_ff <= slot_next;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wr_addr] <= fill_wr_data;
      end
      fill_rd_data <= fill_mem[fill_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_wr_addr] <= item_ff.value;
      end
      entry_rd_data <= entry_mem[entry_rd_addr];
   end

endmodule

// ===== design/bucketed_hash_table_core.sv =====
// Chained hash table of BUCKETS buckets, each holding up to DEPTH values in
// arrival order. A value lands in bucket value modulo BUCKETS.
// Request channel: a beat is taken when req_push is high and req_full is low;
// it carries an insert or a search of one 31-bit value. Response channel: the
// oldest response sits on rsp_data while rsp_empty is low and is taken when
// rsp_pop is high. Every request gives exactly one response, in order.
// The front end finds the bucket by a multiply by the reciprocal of BUCKETS,
// then one subtract, and then hands the work to a two-entry queue. The back
// end takes it and reads the fill count, then decides, and then compares the
// entries in turn (up to DEPTH) from the synchronous entry memory. The front
// end takes no new beat until it has handed the last one to the queue; a
// search holds the back end until its compares end, so long searches limit
// the rate.
// After reset the fill counters are cleared by a pass over all BUCKETS
// counters during which req_full stays high. A stalled receiver holds the
// response in its register; the back end then waits, while the queue and
// front end keep taking beats until they fill.
`include "bucketed_hash_table_core_macros.svh"

module bucketed_hash_table_core import bht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic          front_full;
   logic          hand_push, hand_full;
   work_type      hand_data;
   logic          work_pop, work_empty;
   work_type      work_data;
   back_stat_type back_stat;
   logic          front_push;
   logic          rsp_insert_like, rsp_hit;

   // No beat is taken while the fill counters are being cleared.
   assign front_push = req_push && !back_stat.clearing;
   assign req_full   = front_full || back_stat.clearing;

   bht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (front_push),
      .req_full  (front_full),
      .req_data  (req_data),
      .hand_push (hand_push),
      .hand_full (hand_full),
      .hand_data (hand_data)
   );

   bht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hand_push),
      .full      (hand_full),
      .push_data (hand_data),
      .pop       (work_pop),
      .empty     (work_empty),
      .pop_data  (work_data)
   );

   bht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .work_data  (work_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .stat       (back_stat)
   );

   assign rsp_insert_like = !rsp_empty && (rsp_data.status == STATUS_INSERTED ||
                                           rsp_data.status == STATUS_FULL);
   assign rsp_hit         = !rsp_empty && (rsp_data.status == STATUS_FOUND);

   // Inserts never report a compare count.
   `BHT_ASSERT_IMPLY(a_insert_no_probes, clock, reset, rsp_insert_like, rsp_data.probes == '0)
   // A hit always means at least one entry was compared.
   `BHT_ASSERT_IMPLY(a_found_has_probes, clock, reset, rsp_hit, rsp_data.probes != '0)
   // Taking work from the queue always starts the back end on it.
   `BHT_ASSERT_NEXT(a_pop_starts_back, clock, reset, work_pop && !work_empty, back_stat.busy)
   // A response only appears straight out of a busy back end.
   `BHT_ASSERT_IMPLY(a_rsp_from_back, clock, reset, $rose(!rsp_empty), $past(back_stat.busy))

endmodule
